// ----- rtl/uginterp_pkg.sv -----
// Shared types and constants of the uniform grid interpolator.
// Used by every module of the block except uginterp_ram; no dependencies of its own.
`default_nettype none

package uginterp_pkg;

   // grid size per axis
   localparam int GRID_X = 16;
   localparam int GRID_Y = 16;
   localparam int GRID_Z = 16;
   localparam int GRID_MAX_XY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
   localparam int GRID_MAX = (GRID_MAX_XY > GRID_Z) ? GRID_MAX_XY : GRID_Z;
   localparam int IDX_W = $clog2(GRID_MAX);

   // table geometry
   localparam int ADDR_W = 12;
   localparam int TABLE_DEPTH = 4096;
   localparam int DATA_W = 32;
   localparam int GRID_CELLS_W = $clog2(GRID_X * GRID_Y * GRID_Z) + 1;
   localparam int ADDR_CALC_W = (GRID_CELLS_W > ADDR_W) ? GRID_CELLS_W : ADDR_W;

   // stream packing
   localparam int TDATA_W = 144;
   localparam int OFS_ADDR = 0;
   localparam int OFS_VALUE = 12;
   localparam int OFS_COORD = 44;
   localparam int CSR_INDEX_W = 3;

   // front to back queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // accumulator: up to eight 50-bit products
   localparam int PROD_W = 50;
   localparam int ACC_W = 53;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE    = 3'd0,
      CSR_LOWER_X = 3'd1,
      CSR_LOWER_Y = 3'd2,
      CSR_LOWER_Z = 3'd3,
      CSR_SCALE_X = 3'd4,
      CSR_SCALE_Y = 3'd5,
      CSR_SCALE_Z = 3'd6
   } csr_index_type;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_SUM,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_RUN,
      B_DRAIN,
      B_FINISH
   } back_state_type;

   // per-axis cell description: fraction, node validity, node indexes
   typedef struct packed {
      logic [15:0]      frac;
      logic             ok0;
      logic             ok1;
      logic [IDX_W-1:0] idx0;
      logic [IDX_W-1:0] idx1;
   } axis_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [1:0]        axes;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] value;
      axis_type [2:0]    axis;
   } entry_type;

   typedef struct packed {
      logic [1:0]             mode;
      logic [2:0][DATA_W-1:0] lower;
      logic [2:0][DATA_W-1:0] scale;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/uginterp_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module uginterp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/uginterp_front.sv -----
// Front end: accepts items, maps query coordinates to grid cells, fills the queue.
// Depends on uginterp_pkg.
`default_nettype none

module uginterp_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire uginterp_pkg::cfg_type         cfg,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic                          req_tuser,
   input  wire logic [uginterp_pkg::TDATA_W-1:0] req_tdata,
   input  wire logic                          q_full,
   output logic                               push_valid,
   output uginterp_pkg::entry_type            push_entry
);

   uginterp_pkg::front_state_type state_ff, state_in;
   logic [1:0]                  ax_ff, ax_in;
   logic [1:0]                  axes_ff, axes_in;
   logic signed [32:0]          d_ff [3];
   logic signed [32:0]          d_in [3];
   logic signed [49:0]          lo_ff, lo_in;
   logic signed [48:0]          hi_ff, hi_in;
   uginterp_pkg::entry_type     entry_ff, entry_in;

   logic                        accept;
   uginterp_pkg::entry_type     load_entry;
   logic signed [32:0]          d_sel;
   logic [uginterp_pkg::DATA_W-1:0] scale_sel;
   logic signed [16:0]          scale_lo;
   logic signed [15:0]          scale_hi;
   logic signed [49:0]          u_sum;
   logic signed [33:0]          cell_idx;
   logic signed [33:0]          n_m1;
   logic signed [33:0]          n_m2;
   uginterp_pkg::axis_type      axis_new;
   uginterp_pkg::axis_type      axis_dflt;

   assign req_tready = (state_ff == uginterp_pkg::F_IDLE) && !q_full;
   assign accept = req_tvalid && req_tready;

   // load items go straight into the queue
   always_comb begin
      axis_dflt = '0;
      axis_dflt.ok0 = 1'b1;
      load_entry = '0;
      load_entry.kind = uginterp_pkg::REQ_LOAD;
      load_entry.addr = req_tdata[uginterp_pkg::OFS_ADDR +: uginterp_pkg::ADDR_W];
      load_entry.value = req_tdata[uginterp_pkg::OFS_VALUE +: uginterp_pkg::DATA_W];
      load_entry.axis = {3{axis_dflt}};
   end

   // offset from the lower limit, per axis
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         d_in[a] = $signed({req_tdata[uginterp_pkg::OFS_COORD + 32*a + 31],
                            req_tdata[uginterp_pkg::OFS_COORD + 32*a +: 32]})
                 - $signed({cfg.lower[a][31], cfg.lower[a]});
      end
   end

   // split multiply of offset by scale
   always_comb begin
      d_sel = d_ff[ax_ff];
      scale_sel = cfg.scale[ax_ff];
      scale_lo = $signed({1'b0, scale_sel[15:0]});
      scale_hi = $signed(scale_sel[31:16]);
      lo_in = d_sel * scale_lo;
      hi_in = d_sel * scale_hi;
   end

   // grid units, cell and node validity
   always_comb begin
      u_sum = (lo_ff >>> 16) + hi_ff;
      cell_idx = u_sum[49:16];
      case (ax_ff)
         2'd0: begin
            n_m1 = 34'(uginterp_pkg::GRID_X - 1);
            n_m2 = 34'(uginterp_pkg::GRID_X - 2);
         end
         2'd1: begin
            n_m1 = 34'(uginterp_pkg::GRID_Y - 1);
            n_m2 = 34'(uginterp_pkg::GRID_Y - 2);
         end
         default: begin
            n_m1 = 34'(uginterp_pkg::GRID_Z - 1);
            n_m2 = 34'(uginterp_pkg::GRID_Z - 2);
         end
      endcase
      axis_new.frac = u_sum[15:0];
      axis_new.ok0 = (cell_idx >= 34'sd0) && (cell_idx <= n_m1);
      axis_new.ok1 = (cell_idx >= -34'sd1) && (cell_idx <= n_m2);
      axis_new.idx0 = cell_idx[uginterp_pkg::IDX_W-1:0];
      axis_new.idx1 = cell_idx[uginterp_pkg::IDX_W-1:0] + 1'b1;
   end

   // sequencer: next state and datapath enables
   always_comb begin
      state_in = state_ff;
      ax_in = ax_ff;
      axes_in = axes_ff;
      entry_in = entry_ff;
      push_valid = 1'b0;
      push_entry = load_entry;
      case (state_ff)
         uginterp_pkg::F_IDLE: begin
            if (accept) begin
               if (req_tuser == uginterp_pkg::REQ_LOAD) begin
                  push_valid = 1'b1;
               end else begin
                  axes_in = (cfg.mode == 2'd0) ? 2'd1 : cfg.mode;
                  ax_in = 2'd0;
                  entry_in = load_entry;
                  entry_in.kind = uginterp_pkg::REQ_QUERY;
                  entry_in.axes = axes_in;
                  state_in = uginterp_pkg::F_MUL;
               end
            end
         end
         uginterp_pkg::F_MUL: begin
            state_in = uginterp_pkg::F_SUM;
         end
         uginterp_pkg::F_SUM: begin
            entry_in.axis[ax_ff] = axis_new;
            if (ax_ff == axes_ff - 2'd1) begin
               state_in = uginterp_pkg::F_PUSH;
            end else begin
               ax_in = ax_ff + 2'd1;
               state_in = uginterp_pkg::F_MUL;
            end
         end
         uginterp_pkg::F_PUSH: begin
            push_valid = 1'b1;
            push_entry = entry_ff;
            state_in = uginterp_pkg::F_IDLE;
         end
         default: begin
            state_in = uginterp_pkg::F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uginterp_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ax_ff <= ax_in;
      axes_ff <= axes_in;
      entry_ff <= entry_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (accept) begin
         for (int a = 0; a < 3; a++) begin
            d_ff[a] <= d_in[a];
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/uginterp_queue.sv -----
// Short queue of classified items between front and back end.
// Depends on uginterp_pkg.
`default_nettype none

module uginterp_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire uginterp_pkg::entry_type push_entry,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         head_valid,
   output uginterp_pkg::entry_type      head
);

   uginterp_pkg::entry_type           mem_ff [uginterp_pkg::QDEPTH];
   logic [uginterp_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [uginterp_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [uginterp_pkg::QCNT_W-1:0]   count_ff, count_in;

   assign full = (count_ff == uginterp_pkg::QCNT_W'(uginterp_pkg::QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == uginterp_pkg::QPTR_W'(uginterp_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == uginterp_pkg::QPTR_W'(uginterp_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop)) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("queue pop while empty");
   a_count_drop: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on pop");
`endif

endmodule

`default_nettype wire

// ----- rtl/uginterp_back.sv -----
// Back end: owns the grid table, performs loads and the corner-weighted sums.
// Depends on uginterp_pkg and uginterp_ram.
`default_nettype none

module uginterp_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   input  wire uginterp_pkg::entry_type q_head,
   output logic                         q_pop,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [uginterp_pkg::DATA_W-1:0] rsp_tdata
);

   uginterp_pkg::back_state_type state_ff, state_in;
   uginterp_pkg::entry_type  cur_ff, cur_in;
   logic [2:0]               corner_ff, corner_in;
   logic signed [uginterp_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [uginterp_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // corner pipeline
   logic                     s1_v_ff, s1_last_ff, s1_inside_ff;
   logic [16:0]              s1_w1_ff, s1_wz_ff;
   logic                     s2_v_ff, s2_last_ff;
   logic [16:0]              s2_w_ff;
   logic signed [uginterp_pkg::DATA_W-1:0] s2_data_ff;
   logic                     s3_v_ff, s3_last_ff;
   logic signed [uginterp_pkg::PROD_W-1:0] s3_prod_ff;

   logic                     issue;
   logic                     last_corner;
   logic [2:0]               corner_max;
   logic                     bx, by, bz;
   logic [uginterp_pkg::IDX_W-1:0] ii, jj, kk;
   logic [16:0]              wx, wy, wz;
   logic [33:0]              wxy;
   logic [33:0]              wfull;
   logic                     in_grid;
   logic [uginterp_pkg::ADDR_CALC_W-1:0] a2, a3;
   logic [uginterp_pkg::ADDR_W-1:0] rd_addr;
   logic                     ram_wr;
   logic [uginterp_pkg::DATA_W-1:0] ram_rdata;
   logic signed [36:0]       res_wide;
   logic [uginterp_pkg::DATA_W-1:0] res_sat;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   uginterp_ram #(
      .WIDTH(uginterp_pkg::DATA_W),
      .DEPTH(uginterp_pkg::TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(q_head.addr),
      .wr_data(q_head.value),
      .rd_en  (issue),
      .rd_addr(rd_addr),
      .rd_data(ram_rdata)
   );

   // corner selection, node weights and table address
   always_comb begin
      bx = corner_ff[0];
      by = corner_ff[1];
      bz = corner_ff[2];
      ii = bx ? cur_ff.axis[0].idx1 : cur_ff.axis[0].idx0;
      jj = by ? cur_ff.axis[1].idx1 : cur_ff.axis[1].idx0;
      kk = bz ? cur_ff.axis[2].idx1 : cur_ff.axis[2].idx0;
      wx = bx ? {1'b0, cur_ff.axis[0].frac} : (17'h10000 - {1'b0, cur_ff.axis[0].frac});
      wy = by ? {1'b0, cur_ff.axis[1].frac} : (17'h10000 - {1'b0, cur_ff.axis[1].frac});
      wz = bz ? {1'b0, cur_ff.axis[2].frac} : (17'h10000 - {1'b0, cur_ff.axis[2].frac});
      in_grid = (bx ? cur_ff.axis[0].ok1 : cur_ff.axis[0].ok0)
             && (by ? cur_ff.axis[1].ok1 : cur_ff.axis[1].ok0)
             && (bz ? cur_ff.axis[2].ok1 : cur_ff.axis[2].ok0);
      wxy = wx * wy;
      a2 = uginterp_pkg::ADDR_CALC_W'(ii) * uginterp_pkg::ADDR_CALC_W'(uginterp_pkg::GRID_Y)
         + uginterp_pkg::ADDR_CALC_W'(jj);
      a3 = a2 * uginterp_pkg::ADDR_CALC_W'(uginterp_pkg::GRID_Z)
         + uginterp_pkg::ADDR_CALC_W'(kk);
      case (cur_ff.axes)
         2'd2:    rd_addr = a2[uginterp_pkg::ADDR_W-1:0];
         2'd3:    rd_addr = a3[uginterp_pkg::ADDR_W-1:0];
         default: rd_addr = uginterp_pkg::ADDR_W'(ii);
      endcase
      corner_max = 3'((4'd1 << cur_ff.axes) - 4'd1);
      last_corner = (corner_ff == corner_max);
      wfull = s1_w1_ff * s1_wz_ff;
   end

   // final scaling and saturation
   always_comb begin
      res_wide = 37'(acc_ff >>> 16);
      if (res_wide > 37'sd2147483647) begin
         res_sat = 32'h7FFF_FFFF;
      end else if (res_wide < -37'sd2147483648) begin
         res_sat = 32'h8000_0000;
      end else begin
         res_sat = res_wide[31:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      corner_in = corner_ff;
      q_pop = 1'b0;
      ram_wr = 1'b0;
      issue = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      acc_in = acc_ff;
      if (s3_v_ff) begin
         acc_in = acc_ff + uginterp_pkg::ACC_W'(s3_prod_ff);
      end
      case (state_ff)
         uginterp_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_head.kind == uginterp_pkg::REQ_LOAD) begin
                  ram_wr = 1'b1;
               end else begin
                  cur_in = q_head;
                  corner_in = 3'd0;
                  acc_in = '0;
                  state_in = uginterp_pkg::B_RUN;
               end
            end
         end
         uginterp_pkg::B_RUN: begin
            issue = 1'b1;
            if (last_corner) begin
               state_in = uginterp_pkg::B_DRAIN;
            end else begin
               corner_in = corner_ff + 3'd1;
            end
         end
         uginterp_pkg::B_DRAIN: begin
            if (s3_v_ff && s3_last_ff) begin
               state_in = uginterp_pkg::B_FINISH;
            end
         end
         uginterp_pkg::B_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_sat;
               state_in = uginterp_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = uginterp_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uginterp_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // payload and pipeline data
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      corner_ff <= corner_in;
      acc_ff <= acc_in;
      rsp_data_ff <= rsp_data_in;
      s1_last_ff <= last_corner;
      s1_inside_ff <= in_grid;
      s1_w1_ff <= wxy[32:16];
      s1_wz_ff <= wz;
      s2_last_ff <= s1_last_ff;
      s2_w_ff <= wfull[32:16];
      s2_data_ff <= s1_inside_ff ? $signed(ram_rdata) : '0;
      s3_last_ff <= s2_last_ff;
      s3_prod_ff <= s2_data_ff * $signed({1'b0, s2_w_ff});
   end

`ifndef NO_ASSERTIONS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == uginterp_pkg::B_IDLE)) else $error("queue pop while busy");
   a_last_to_finish: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && s3_last_ff) |=> (state_ff == uginterp_pkg::B_FINISH))
      else $error("last corner did not end the sum");
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == uginterp_pkg::B_FINISH))
      else $error("result raised outside finish");
   a_issue_only_run: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> ($past(state_ff) == uginterp_pkg::B_RUN))
      else $error("corner issued outside run");
`endif

endmodule

`default_nettype wire

// ----- rtl/uniform_grid_multilinear_interp_core.sv -----
// Uniform grid linear, bilinear or trilinear interpolator, top level.
// Holds the configuration registers; depends on uginterp_pkg, uginterp_front,
// uginterp_queue and uginterp_back.
//
// Usage:
//   csr_*  : register writes (index 0 mode, 1..3 lower x/y/z, 4..6 scale x/y/z),
//            always ready; write only while the block is idle.
//   req_*  : items; tuser 0 loads one table entry, 1 queries one point.
//   rsp_*  : one interpolated value per query, none per load.
// Timing: on a query the front end steps through a multiply and a sum state
//   for each used axis and then a push state; a load is pushed when accepted.
//   Both go to a 2-entry queue. The back end pops an item, writes a load
//   into the table or reads one corner per cycle (2^axes) for a query,
//   drains the multiply-accumulate pipeline and finishes with the result.
// Reset: mode 3, lower limits 0, scales 1.0; queue and result register empty.
//   The table is not cleared: every entry must be loaded before it is read.
// Stall: a result waits in the output register while rsp_tready is low; the
//   back end holds its next result, and the front keeps taking items until
//   the queue is full.
`default_nettype none

module uniform_grid_multilinear_interp_core (
   input  wire logic         clock,
   input  wire logic         reset,
   // configuration write channel
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data,
   // item channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic         req_tuser,   // req_type
   input  wire logic [143:0] req_tdata,   // table_addr, table_value, coord_x, coord_y, coord_z, pad
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata    // interp_value
);

   logic [1:0]              mode_ff;
   logic [2:0][31:0]        lower_ff;
   logic [2:0][31:0]        scale_ff;
   uginterp_pkg::cfg_type   cfg;

   logic                    q_full;
   logic                    push_valid;
   uginterp_pkg::entry_type push_entry;
   logic                    q_pop;
   logic                    q_valid;
   uginterp_pkg::entry_type q_head;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd3;
         lower_ff <= '0;
         scale_ff <= {3{32'h0001_0000}};
      end else if (csr_valid && csr_ready) begin
         case (uginterp_pkg::csr_index_type'(csr_index))
            uginterp_pkg::CSR_MODE:    mode_ff <= csr_data[1:0];
            uginterp_pkg::CSR_LOWER_X: lower_ff[0] <= csr_data;
            uginterp_pkg::CSR_LOWER_Y: lower_ff[1] <= csr_data;
            uginterp_pkg::CSR_LOWER_Z: lower_ff[2] <= csr_data;
            uginterp_pkg::CSR_SCALE_X: scale_ff[0] <= csr_data;
            uginterp_pkg::CSR_SCALE_Y: scale_ff[1] <= csr_data;
            uginterp_pkg::CSR_SCALE_Z: scale_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.mode = mode_ff;
      cfg.lower = lower_ff;
      cfg.scale = scale_ff;
   end

   uginterp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .q_full    (q_full),
      .push_valid(push_valid),
      .push_entry(push_entry)
   );

   uginterp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_entry(push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head      (q_head)
   );

   uginterp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire
